@@ rtl/assert_macros.svh @@
// Assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(name, clk, rst, ante, cons)

`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

@@ rtl/fvc_pkg.sv @@
`timescale 1ns / 1ps
package fvc_pkg;

  localparam int COS_TABLE_BITS = 10;
  localparam int COS_QBITS      = COS_TABLE_BITS - 2;
  localparam int COS_ENTRIES    = (1 << COS_QBITS) + 1;
  localparam int COS_IDX_W      = COS_QBITS + 1;

  localparam int RECIP_BITS = 17;
  localparam int REM_W      = 49;
  localparam int DEN_W      = 64;
  localparam int TRIAL_W    = DEN_W + RECIP_BITS - 1;

  localparam int PIPE_LAST = 25;
  localparam int HSV_DEPTH = 24;
  localparam int EARLY_DEPTH = 3;

  localparam logic [26:0] FREQ_Q32   = 27'd102534791;
  localparam logic [31:0] PHASE_R    = 32'd2050695827;
  localparam logic [31:0] PHASE_G    = 32'd2460834992;
  localparam logic [31:0] PHASE_B    = 32'd2734261102;
  localparam logic [63:0] ONE_Q30    = 64'd1073741824;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [12:0] MOD100_MUL = 13'd5242;
  localparam logic [25:0] DIV50_MUL  = 26'd42949673;

  typedef enum logic [1:0] {
    MODE_BLACK  = 2'd0,
    MODE_COSINE = 2'd1,
    MODE_GRAY   = 2'd2,
    MODE_HSV    = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef logic [7:0] cos_tab_t [COS_ENTRIES];

  function automatic logic [63:0] horner_step(input logic [63:0] d);
    return (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
  endfunction

  function automatic logic [63:0] sine_quarter(input logic [63:0] u_in);
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    u  = (u_in > ONE_Q30) ? ONE_Q30 : u_in;
    x  = (u * PI_HALF_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = horner_step(((x2 * t) >> 30) / 64'd110);
    t  = horner_step(((x2 * t) >> 30) / 64'd72);
    t  = horner_step(((x2 * t) >> 30) / 64'd42);
    t  = horner_step(((x2 * t) >> 30) / 64'd20);
    t  = horner_step(((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    return (s > ONE_Q30) ? ONE_Q30 : s;
  endfunction

  function automatic cos_tab_t make_cos_tab(input logic up);
    cos_tab_t    tab;
    logic [63:0] s;
    logic [63:0] p;
    logic [63:0] v;
    for (int k = 0; k < COS_ENTRIES; k++) begin
      s = sine_quarter(64'(k) << (30 - COS_QBITS));
      p = up ? ONE_Q30 + s : ONE_Q30 - s;
      v = (64'd255 * p) >> 31;
      tab[k] = (v > 64'd255) ? 8'd255 : v[7:0];
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_UP = make_cos_tab(1'b1);
  localparam cos_tab_t COS_DN = make_cos_tab(1'b0);

  function automatic logic [7:0] cos_byte(input logic [31:0] a);
    logic [COS_IDX_W-1:0] k;
    logic [COS_IDX_W-1:0] kr;
    logic [7:0]           b;
    k  = {1'b0, a[29 -: COS_QBITS]};
    kr = COS_IDX_W'(COS_ENTRIES - 1) - k;
    case (a[31:30])
      2'd0:    b = COS_UP[kr];
      2'd1:    b = COS_DN[k];
      2'd2:    b = COS_DN[kr];
      default: b = COS_UP[k];
    endcase
    return b;
  endfunction

endpackage

@@ rtl/fvc_recip.sv @@
`timescale 1ns / 1ps
module fvc_recip (
  input  logic                              clk,
  input  logic                              en,
  input  logic [fvc_pkg::DEN_W-1:0]         sq,
  output logic [fvc_pkg::RECIP_BITS-1:0]    quo
);

  localparam logic [fvc_pkg::REM_W-1:0] REM_INIT = fvc_pkg::REM_W'(1) << 48;

  logic [fvc_pkg::DEN_W-1:0]      dv [fvc_pkg::RECIP_BITS-1];
  logic [fvc_pkg::REM_W-1:0]      rm [fvc_pkg::RECIP_BITS-1];
  logic [fvc_pkg::RECIP_BITS-1:0] qt [fvc_pkg::RECIP_BITS];

  logic [fvc_pkg::DEN_W-1:0]      d_in   [fvc_pkg::RECIP_BITS];
  logic [fvc_pkg::REM_W-1:0]      r_in   [fvc_pkg::RECIP_BITS];
  logic [fvc_pkg::RECIP_BITS-1:0] q_in   [fvc_pkg::RECIP_BITS];
  logic [fvc_pkg::TRIAL_W-1:0]    trial  [fvc_pkg::RECIP_BITS];
  logic                           ge     [fvc_pkg::RECIP_BITS];

  for (genvar i = 0; i < fvc_pkg::RECIP_BITS; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign d_in[i] = sq + 64'h0000_0001_0000_0000;
      assign r_in[i] = REM_INIT;
      assign q_in[i] = '0;
    end else begin : g_next
      assign d_in[i] = dv[i-1];
      assign r_in[i] = rm[i-1];
      assign q_in[i] = qt[i-1];
    end
    assign trial[i] = {{(fvc_pkg::RECIP_BITS-1){1'b0}}, d_in[i]}
                      << (fvc_pkg::RECIP_BITS - 1 - i);
    assign ge[i] = {{(fvc_pkg::TRIAL_W-fvc_pkg::REM_W){1'b0}}, r_in[i]} >= trial[i];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < fvc_pkg::RECIP_BITS - 1; i++) begin
        dv[i] <= d_in[i];
        rm[i] <= ge[i] ? r_in[i] - trial[i][fvc_pkg::REM_W-1:0] : r_in[i];
      end
      for (int i = 0; i < fvc_pkg::RECIP_BITS; i++) begin
        qt[i] <= q_in[i] | (ge[i] ? (fvc_pkg::RECIP_BITS'(1) << (fvc_pkg::RECIP_BITS - 1 - i))
                                  : '0);
      end
    end
  end

  assign quo = qt[fvc_pkg::RECIP_BITS-1];

endmodule

@@ rtl/fvc_hsv.sv @@
`timescale 1ns / 1ps
module fvc_hsv (
  input  logic            clk,
  input  logic            en,
  input  logic [31:0]     n,
  output fvc_pkg::pixel_t pix
);

  localparam int HUE_TAPS = 19;

  logic [63:0] sq;
  logic [15:0] xh1;
  logic [15:0] lo1;
  logic [9:0]  qm;
  logic [6:0]  rr2;
  logic [15:0] lo2;
  logic [18:0] hd [HUE_TAPS];
  logic [fvc_pkg::RECIP_BITS-1:0] quo;
  logic [16:0] lz;
  logic [16:0] lz20;
  logic [16:0] l2;
  logic [16:0] v;
  logic [15:0] c22;
  logic [16:0] m22;
  logic [15:0] xx;
  logic [2:0]  sec22;
  logic [16:0] chr;
  logic [16:0] chg;
  logic [16:0] chb;

  logic [28:0] prod_q;
  logic [16:0] q100;
  logic [15:0] t2;
  logic [22:0] rem3;
  logic [24:0] y3;
  logic [50:0] prod_h;
  logic [16:0] qsat;
  logic [33:0] lzsq;
  logic [33:0] vprod;
  logic [15:0] c21;
  logic [16:0] m21;
  logic [2:0]  sec21;
  logic [15:0] f21;
  logic [16:0] fac;
  logic [32:0] xprod;
  logic [16:0] sr;
  logic [16:0] sg;
  logic [16:0] sb;

  function automatic logic [7:0] to_byte(input logic [16:0] ch);
    logic [24:0] p;
    p = {ch, 8'b0} - {8'b0, ch};
    return (p[24:16] > 9'd255) ? 8'd255 : p[23:16];
  endfunction

  fvc_recip u_recip (
    .clk (clk),
    .en  (en),
    .sq  (sq),
    .quo (quo)
  );

  always_comb begin
    prod_q = {13'b0, n[31:16]} * {16'b0, fvc_pkg::MOD100_MUL};
    q100   = {7'b0, qm} * 17'd100;
    t2     = xh1 - q100[15:0];
    rem3   = {rr2, lo2};
    y3     = {2'b0, rem3} + {1'b0, rem3, 1'b0};
    prod_h = {26'b0, y3} * {25'b0, fvc_pkg::DIV50_MUL};
    qsat   = (quo > 17'd65536) ? 17'd65536 : quo;
    lzsq   = {17'b0, lz} * {17'b0, lz};
    vprod  = {17'b0, l2} * {17'b0, lz20};
    c21    = v[16:1];
    m21    = v - {1'b0, c21};
    sec21  = hd[HUE_TAPS-1][18:16];
    f21    = hd[HUE_TAPS-1][15:0];
    fac    = sec21[0] ? 17'd65536 - {1'b0, f21} : {1'b0, f21};
    xprod  = {17'b0, c21} * {16'b0, fac};
  end

  always_comb begin
    sr = '0;
    sg = '0;
    sb = '0;
    case (sec22)
      3'd0: begin
        sr = {1'b0, c22};
        sg = {1'b0, xx};
      end
      3'd1: begin
        sr = {1'b0, xx};
        sg = {1'b0, c22};
      end
      3'd2: begin
        sg = {1'b0, c22};
        sb = {1'b0, xx};
      end
      3'd3: begin
        sg = {1'b0, xx};
        sb = {1'b0, c22};
      end
      3'd4: begin
        sr = {1'b0, xx};
        sb = {1'b0, c22};
      end
      3'd5: begin
        sr = {1'b0, c22};
        sb = {1'b0, xx};
      end
      default: begin
        sr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq    <= {32'b0, n} * {32'b0, n};
      xh1   <= n[31:16];
      lo1   <= n[15:0];
      qm    <= prod_q[28:19];
      rr2   <= (t2 >= 16'd100) ? 7'(t2 - 16'd100) : t2[6:0];
      lo2   <= lo1;
      hd[0] <= prod_h[49:31];
      for (int i = 1; i < HUE_TAPS; i++) begin
        hd[i] <= hd[i-1];
      end
      lz    <= 17'd65536 - qsat;
      l2    <= lzsq[32:16];
      lz20  <= lz;
      v     <= vprod[32:16];
      c22   <= c21;
      m22   <= m21;
      xx    <= xprod[31:16];
      sec22 <= sec21;
      chr   <= sr + m22;
      chg   <= sg + m22;
      chb   <= sb + m22;
      pix.red   <= to_byte(chr);
      pix.green <= to_byte(chg);
      pix.blue  <= to_byte(chb);
    end
  end

endmodule

@@ rtl/fvc_palette.sv @@
`timescale 1ns / 1ps
module fvc_palette (
  input  logic            clk,
  input  logic            en,
  input  logic [31:0]     n,
  output fvc_pkg::pixel_t pix
);

  logic [31:0] turns;
  logic [58:0] prod;

  assign prod = {27'b0, n} * {32'b0, fvc_pkg::FREQ_Q32};

  always_ff @(posedge clk) begin
    if (en) begin
      turns     <= prod[47:16];
      pix.red   <= fvc_pkg::cos_byte(turns + fvc_pkg::PHASE_R);
      pix.green <= fvc_pkg::cos_byte(turns + fvc_pkg::PHASE_G);
      pix.blue  <= fvc_pkg::cos_byte(turns + fvc_pkg::PHASE_B);
    end
  end

endmodule

@@ rtl/fractal_value_colorizer.sv @@
`timescale 1ns / 1ps
// Path from input transaction to result valid: input register, 24 compute stages
// behind it, then the output register; throughput one pixel per cycle unless out_ready stalls the output.
// The depth is set by the 17-stage reciprocal divider of the HSV brightness.
// A one-entry skid buffer takes one more sample while the result waits; in_ready then drops.
// Reset (rst, synchronous) clears valid bits, skid buffer and color_mode to 0.
`include "assert_macros.svh"
module fractal_value_colorizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] sample_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  localparam int EARLY_TAPS = fvc_pkg::HSV_DEPTH - fvc_pkg::EARLY_DEPTH + 1;

  fvc_pkg::mode_t  color_mode;
  logic            skid_full;
  logic [31:0]     skid_n;
  logic [fvc_pkg::PIPE_LAST:0] vld;
  fvc_pkg::mode_t  md [fvc_pkg::PIPE_LAST+1];
  logic [31:0]     n0;
  logic [7:0]      g1;
  logic [7:0]      g2;
  fvc_pkg::pixel_t ed [EARLY_TAPS];
  fvc_pkg::pixel_t pal_pix;
  fvc_pkg::pixel_t hsv_pix;
  fvc_pkg::pixel_t early_next;
  fvc_pkg::pixel_t out_pix;

  logic        adv;
  logic        src_v;
  logic [31:0] src_n;
  logic [39:0] gprod;
  logic        out_is_black;
  logic        out_is_gray;

  assign adv      = !vld[fvc_pkg::PIPE_LAST] || out_ready;
  assign in_ready = !skid_full;
  assign src_v    = skid_full || in_valid;
  assign src_n    = skid_full ? skid_n : sample_value;
  assign gprod    = {n0, 8'b0} - {8'b0, n0};

  always_comb begin
    case (md[2])
      fvc_pkg::MODE_COSINE: early_next = pal_pix;
      fvc_pkg::MODE_GRAY:   early_next = '{red: g2, green: g2, blue: g2};
      default:              early_next = '0;
    endcase
  end

  fvc_palette u_palette (
    .clk (clk),
    .en  (adv),
    .n   (n0),
    .pix (pal_pix)
  );

  fvc_hsv u_hsv (
    .clk (clk),
    .en  (adv),
    .n   (n0),
    .pix (hsv_pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= fvc_pkg::MODE_BLACK;
      skid_full  <= 1'b0;
      vld        <= '0;
    end else begin
      if (cfg_we) begin
        color_mode <= fvc_pkg::mode_t'(cfg_wdata);
      end
      if (adv) begin
        vld <= {vld[fvc_pkg::PIPE_LAST-1:0], src_v};
        skid_full <= 1'b0;
      end else if (in_valid && in_ready) begin
        skid_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_valid && in_ready) begin
      skid_n <= sample_value;
    end
    if (adv) begin
      n0    <= src_n;
      md[0] <= color_mode;
      for (int i = 1; i <= fvc_pkg::PIPE_LAST; i++) begin
        md[i] <= md[i-1];
      end
      g1    <= (gprod[39:24] != 16'd0) ? 8'd255 : gprod[23:16];
      g2    <= g1;
      ed[0] <= early_next;
      for (int i = 1; i < EARLY_TAPS; i++) begin
        ed[i] <= ed[i-1];
      end
      out_pix <= (md[fvc_pkg::HSV_DEPTH] == fvc_pkg::MODE_HSV) ? hsv_pix : ed[EARLY_TAPS-1];
    end
  end

  assign out_valid = vld[fvc_pkg::PIPE_LAST];
  assign red       = out_pix.red;
  assign green     = out_pix.green;
  assign blue      = out_pix.blue;

  assign out_is_black = out_valid && md[fvc_pkg::PIPE_LAST] == fvc_pkg::MODE_BLACK;
  assign out_is_gray  = out_valid && md[fvc_pkg::PIPE_LAST] == fvc_pkg::MODE_GRAY;

  `ASSERT_IMPL(a_black_out, clk, rst, out_is_black, red == 8'd0 && green == 8'd0 && blue == 8'd0)
  `ASSERT_IMPL(a_gray_out, clk, rst, out_is_gray, red == green && green == blue)
  `ASSERT_NEXT(a_stall_hold, clk, rst, !rst && !adv, $stable(vld))

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;

  localparam longint unsigned Q30 = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned FREQ = 64'd102534791;
  localparam int DRAIN_CYCLES = 40;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] sample_value;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;

  int error_count;

  fractal_value_colorizer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample_value(sample_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .red(red), .green(green), .blue(blue),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic longint unsigned quarter_sine(input longint unsigned u_in);
    longint unsigned u, x, x2, t, d, s;
    longint unsigned divs[5];
    divs = '{110, 72, 42, 20, 6};
    u = (u_in > Q30) ? Q30 : u_in;
    x = (u * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t = Q30;
    for (int k = 0; k < 5; k++) begin
      d = ((x2 * t) >> 30) / divs[k];
      t = (d >= Q30) ? 0 : Q30 - d;
    end
    s = (x * t) >> 30;
    return (s > Q30) ? Q30 : s;
  endfunction

  function automatic logic [7:0] palette_byte(input logic [31:0] turns, input logic [31:0] ph);
    logic [31:0] a, at;
    longint unsigned u, p, v;
    a = turns + ph;
    at = (a >> (32 - fvc_pkg::COS_TABLE_BITS)) << (32 - fvc_pkg::COS_TABLE_BITS);
    u = 64'(at[29:0]);
    case (at[31:30])
      2'd0: p = Q30 + quarter_sine(Q30 - u);
      2'd1: p = Q30 - quarter_sine(u);
      2'd2: p = Q30 - quarter_sine(Q30 - u);
      default: p = Q30 + quarter_sine(u);
    endcase
    v = (255 * p) >> 31;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [7:0] q16_byte(input longint unsigned ch);
    longint unsigned v;
    v = (255 * ch) >> 16;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic fvc_pkg::pixel_t color_pixel(input fvc_pkg::mode_t mode,
                                                  input logic [31:0] n);
    fvc_pkg::pixel_t px;
    longint unsigned turns64, v, rem, h1, f, sq, rec, lz, bright, c, m, xx, cr, cg, cb;
    logic [2:0] sector;
    px = '0;
    case (mode)
      fvc_pkg::MODE_COSINE: begin
        turns64 = (64'(n) * FREQ) >> 16;
        px.red = palette_byte(turns64[31:0], fvc_pkg::PHASE_R);
        px.green = palette_byte(turns64[31:0], fvc_pkg::PHASE_G);
        px.blue = palette_byte(turns64[31:0], fvc_pkg::PHASE_B);
      end
      fvc_pkg::MODE_GRAY: begin
        v = (64'(n) * 255) >> 16;
        px.red = (v > 255) ? 8'd255 : v[7:0];
        px.green = px.red;
        px.blue = px.red;
      end
      fvc_pkg::MODE_HSV: begin
        rem = 64'(n) % 64'd6553600;
        h1 = (rem * 3) / 50;
        sector = h1[18:16];
        f = h1 & 64'hFFFF;
        sq = 64'(n) * 64'(n);
        rec = (64'd1 << 48) / (sq + (64'd1 << 32));
        lz = 65536 - ((rec > 65536) ? 65536 : rec);
        bright = (((lz * lz) >> 16) * lz) >> 16;
        c = bright >> 1;
        m = bright - c;
        xx = sector[0] ? (c * (65536 - f)) >> 16 : (c * f) >> 16;
        cr = 0;
        cg = 0;
        cb = 0;
        case (sector)
          3'd0: begin cr = c; cg = xx; end
          3'd1: begin cr = xx; cg = c; end
          3'd2: begin cg = c; cb = xx; end
          3'd3: begin cg = xx; cb = c; end
          3'd4: begin cr = xx; cb = c; end
          3'd5: begin cr = c; cb = xx; end
          default: ;
        endcase
        px.red = q16_byte(cr + m);
        px.green = q16_byte(cg + m);
        px.blue = q16_byte(cb + m);
      end
      default: ;
    endcase
    return px;
  endfunction

  class pixel_scoreboard;
    fvc_pkg::pixel_t pending[$];
    fvc_pkg::mode_t mode;

    function void note_sample(input logic [31:0] n);
      pending.insert(pending.size(), color_pixel(mode, n));
    endfunction

    task check_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      fvc_pkg::pixel_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected pixel %0d %0d %0d", r, g, b));
        return;
      end
      want = pending.pop_front();
      if (r !== want.red) report($sformatf("red %0d, want %0d", r, want.red));
      if (g !== want.green) report($sformatf("green %0d, want %0d", g, want.green));
      if (b !== want.blue) report($sformatf("blue %0d, want %0d", b, want.blue));
    endtask
  endclass

  pixel_scoreboard board;

  initial begin
    board = new();
    board.mode = fvc_pkg::MODE_BLACK;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_sample(sample_value);
      if (out_valid && out_ready) board.check_pixel(red, green, blue);
    end
  end

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst) @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 13)) @(posedge clk);
        out_ready <= 1'b1;
        @(posedge clk);
        while (!(out_valid && out_ready)) @(posedge clk);
      end
    end
  end

  task automatic send_sample(input logic [31:0] n, input bit pause);
    if (pause) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_value <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic set_mode(input fvc_pkg::mode_t mode);
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    board.mode = mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] random_sample();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 32'h0002_0000);
      1: return $urandom_range(0, 32'h0064_0000);
      2: return $urandom_range(0, 32'h0200_0000);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      default: return $urandom();
    endcase
  endfunction

  logic [31:0] directed[$] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_FFFF,
    32'h0001_0101, 32'h0100_0000, 32'h0063_FFFF, 32'h0064_0000, 32'h0010_AAAA,
    32'h0021_5555, 32'h0032_0000, 32'h0043_0000, 32'h0054_0000, 32'h8000_0000,
    32'h5555_5555, 32'hAAAA_AAAA};

  initial begin
    fvc_pkg::mode_t order[$];
    error_count = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    sample_value <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= fvc_pkg::MODE_BLACK;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_sample(directed[i], 1'b0);
    order = '{fvc_pkg::MODE_HSV, fvc_pkg::MODE_COSINE, fvc_pkg::MODE_GRAY,
              fvc_pkg::MODE_BLACK, fvc_pkg::MODE_HSV, fvc_pkg::MODE_COSINE};
    foreach (order[p]) begin
      set_mode(order[p]);
      foreach (directed[i]) send_sample(directed[i], i % 3 == 0);
      for (int k = 0; k < 290; k++) begin
        if (k >= 120 && k < 200) send_sample(random_sample(), 1'b0);
        else send_sample(random_sample(), 1'($urandom_range(0, 1)));
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/fvc_pkg.sv
rtl/fvc_recip.sv
rtl/fvc_hsv.sv
rtl/fvc_palette.sv
rtl/fractal_value_colorizer.sv
sim/tb.sv
